// ===== hw/rtl/mmdn_pkg.sv =====
// Shared types and constants for the min/max display normalizer.
// No dependencies; used by every module of the block.
package mmdn_pkg;

    // sample and register widths
    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 24;
    localparam int CMP_W    = (SAMPLE_W > CFG_W) ? SAMPLE_W : CFG_W;
    localparam int PIX_W    = 8;
    localparam int FUNC_W   = 2;
    // dividend num*510 + span needs SAMPLE_W + 9 bits, plus one of headroom
    localparam int REM_W    = SAMPLE_W + 10;
    // one divider cell per quotient bit
    localparam int N_CELLS  = PIX_W;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_MEASURE = 2'd1,
        FUNC_CONVERT = 2'd2
    } t_func;

    // convert item after range classification
    typedef struct packed {
        logic                valid;
        logic                bypass;  // pixel already known (flat or clamped)
        logic                flat;
        logic [PIX_W-1:0]    pix;
        logic [SAMPLE_W-1:0] num;     // sample - range_low
        logic [SAMPLE_W-1:0] span;    // range_high - range_low
    } t_front;

    // item travelling down the divider chain
    typedef struct packed {
        logic             valid;
        logic             bypass;
        logic             flat;
        logic [PIX_W-1:0] pix;        // quotient bits shifted in, or fixed value
        logic [REM_W-1:0] rem;        // partial remainder
        logic [REM_W-1:0] dsr;        // divisor aligned to the top quotient bit
    } t_stage;

endpackage

// ===== hw/rtl/mmdn_range.sv =====
// Range tracker and front classification stage of the normalizer.
// Holds min/max/seen and the span floor; depends on mmdn_pkg.
module mmdn_range
    import mmdn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,        // chain advances this cycle
    input  logic                i_acc,       // input transaction taken
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,
    output t_front              o_front
);

    localparam logic signed [SAMPLE_W-1:0] MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] r_low, n_low;
    logic signed [SAMPLE_W-1:0] r_high, n_high;
    logic                       r_seen, n_seen;
    logic [CFG_W-1:0]           r_min_span;
    t_front                     r_front, n_front;

    logic signed [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0]        span;
    logic                       is_flat;

    assign v    = i_sample;
    assign span = SAMPLE_W'(r_high - r_low);

    // flat when nothing measured, inverted range, or span at or under the floor
    assign is_flat = !r_seen || (r_high < r_low) ||
                     (CMP_W'(span) <= CMP_W'(r_min_span));

    // range update and convert classification
    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_seen  = r_seen;
        n_front = '0;
        if (i_acc) begin
            unique case (i_func)
                FUNC_CLEAR: begin
                    n_low  = MOST_POS;
                    n_high = MOST_NEG;
                    n_seen = 1'b0;
                end
                FUNC_MEASURE: begin
                    if (v < r_low)  n_low  = v;
                    if (v > r_high) n_high = v;
                    n_seen = 1'b1;
                end
                FUNC_CONVERT: begin
                    n_front.valid = 1'b1;
                    n_front.num   = SAMPLE_W'(v - r_low);
                    n_front.span  = span;
                    if (is_flat) begin
                        n_front.bypass = 1'b1;
                        n_front.flat   = 1'b1;
                    end else if (v <= r_low) begin
                        n_front.bypass = 1'b1;
                    end else if (v >= r_high) begin
                        n_front.bypass = 1'b1;
                        n_front.pix    = PIX_MAX;
                    end
                end
                default: ;  // unused code: ignored
            endcase
        end
    end

    // range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= MOST_POS;
            r_high <= MOST_NEG;
            r_seen <= 1'b0;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
            r_seen <= n_seen;
        end
    end

    // span floor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_span <= '0;
        end else if (i_cfg_wr_en) begin
            r_min_span <= i_cfg_wr_data;
        end
    end

    // front stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

// ===== hw/rtl/mmdn_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit per pass.
// Depends on mmdn_pkg; chained N_CELLS deep in the top level.
module mmdn_div_cell
    import mmdn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage           r_stage, n_stage;
    logic             ge;
    logic [REM_W-1:0] diff;

    assign ge   = (i_stage.rem >= i_stage.dsr);
    assign diff = i_stage.rem - i_stage.dsr;

    // subtract if it fits, double the remainder, shift in the quotient bit unless bypassed
    always_comb begin
        n_stage     = i_stage;
        n_stage.rem = ge ? {diff[REM_W-2:0], 1'b0} : {i_stage.rem[REM_W-2:0], 1'b0};
        if (!i_stage.bypass) begin
            n_stage.pix = {i_stage.pix[PIX_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/min_max_display_normalizer.sv =====
// Min/max display normalizer: range tracking plus an 8-cell divider chain.
// A transaction passes the front register, the prep register and the 8 cells.
// Throughput: one transaction per cycle; the whole chain stalls while the
// result in the last cell is not taken. Clear/measure items give no result.
// Reset (i_rst_n, synchronous, active low) empties the chain, sets the range
// to empty and the span floor to 0. Depends on mmdn_pkg, mmdn_range, mmdn_div_cell.
module min_max_display_normalizer
    import mmdn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [SAMPLE_W-1:0] i_s_tdata,     // [23:0] sample
    input  logic [FUNC_W-1:0]   i_s_tuser,     // [1:0] func
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [PIX_W-1:0]    o_m_tdata,     // [7:0] pixel
    output logic                o_m_tuser,     // [0] flat
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data  // min_span
);

    logic   en;
    logic   acc;
    t_front front;
    t_stage r_prep, n_prep;
    t_stage chain [N_CELLS+1];

    // whole chain moves unless a finished result is held back
    assign en         = !chain[N_CELLS].valid || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;

    mmdn_range u_range (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_acc         (acc),
        .i_func        (i_s_tuser),
        .i_sample      (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_front       (front)
    );

    // dividend num*510 + span, divisor 2*span aligned to quotient bit 7
    always_comb begin
        n_prep        = '0;
        n_prep.valid  = front.valid;
        n_prep.bypass = front.bypass;
        n_prep.flat   = front.flat;
        n_prep.pix    = front.pix;
        n_prep.rem    = (REM_W'(front.num) << 9) - (REM_W'(front.num) << 1)
                        + REM_W'(front.span);
        n_prep.dsr    = REM_W'(front.span) << PIX_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else if (en) begin
            r_prep <= n_prep;
        end
    end

    assign chain[0] = r_prep;

    // divider chain, one quotient bit per cell
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        mmdn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    assign o_m_tvalid = chain[N_CELLS].valid;
    assign o_m_tdata  = chain[N_CELLS].pix;
    assign o_m_tuser  = chain[N_CELLS].flat;

endmodule
